@@ design/h2rgb_pkg.sv @@
// shared types, constants and helpers for the hsv to rgb conversion core
// no dependencies

package h2rgb_pkg;

    localparam int FRAC_BITS  = 12;
    localparam int FIELD_W    = FRAC_BITS + 1;
    localparam int H6_W       = FRAC_BITS + 3;
    localparam int SEC_W      = 3;
    localparam int BYTE_W     = 8;
    localparam int NUM_STAGES = 4;

    localparam logic [FIELD_W-1:0] ONE_VAL = FIELD_W'(1) << FRAC_BITS;

    // colour hexagon sector, from the integer part of hue times six
    typedef enum logic [SEC_W-1:0] {
        SEC_RED_YEL = 3'd0,
        SEC_YEL_GRN = 3'd1,
        SEC_GRN_CYN = 3'd2,
        SEC_CYN_BLU = 3'd3,
        SEC_BLU_MAG = 3'd4,
        SEC_MAG_RED = 3'd5,
        SEC_WRAP    = 3'd6
    } t_sector;

    typedef logic [FIELD_W-1:0] t_level;
    typedef logic [BYTE_W-1:0]  t_byte;

    typedef struct packed {
        logic [NUM_STAGES-1:0] load;
        logic                  in_ready;
        logic                  out_valid;
    } t_pipe_ctl;

    // saturate a field to one
    function automatic t_level clamp_one(input t_level x);
        return (x > ONE_VAL) ? ONE_VAL : x;
    endfunction

    // (level * 255) >> FRAC_BITS
    function automatic t_byte to_byte(input t_level lvl);
        logic [FIELD_W+BYTE_W-1:0] prod;
        prod = {lvl, {BYTE_W{1'b0}}} - {{BYTE_W{1'b0}}, lvl};
        return prod[FRAC_BITS+BYTE_W-1:FRAC_BITS];
    endfunction

endpackage

@@ design/h2rgb_ifs.sv @@
// handshake channel interfaces: hsv input and rgb output
// depends on h2rgb_pkg

interface h2rgb_hsv_if
    import h2rgb_pkg::*;
;
    logic   valid;
    logic   ready;
    t_level hue;
    t_level saturation;
    t_level brightness;

    modport source (output valid, output hue, output saturation, output brightness,
                    input ready);
    modport sink   (input valid, input hue, input saturation, input brightness,
                    output ready);
endinterface

interface h2rgb_rgb_if
    import h2rgb_pkg::*;
;
    logic  valid;
    logic  ready;
    t_byte red;
    t_byte green;
    t_byte blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

@@ design/h2rgb_pipe_ctl.sv @@
// valid tracking and stage load enables for the conversion pipeline
// depends on h2rgb_pkg

module h2rgb_pipe_ctl
    import h2rgb_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_out_ready,
    output t_pipe_ctl o_ctl
);

    logic [NUM_STAGES-1:0] r_valid;
    logic [NUM_STAGES-1:0] n_valid;
    logic [NUM_STAGES-1:0] stage_ready;
    logic [NUM_STAGES-1:0] up_valid;

    always_comb begin
        // a stage takes new data when empty or when its content moves on
        for (int k = NUM_STAGES - 1; k >= 0; k--) begin
            if (k == NUM_STAGES - 1) begin
                stage_ready[k] = !r_valid[k] || i_out_ready;
            end else begin
                stage_ready[k] = !r_valid[k] || stage_ready[k+1];
            end
        end
        for (int k = 0; k < NUM_STAGES; k++) begin
            up_valid[k] = (k == 0) ? i_in_valid : r_valid[(k == 0) ? 0 : k - 1];
            n_valid[k]  = stage_ready[k] ? up_valid[k] : r_valid[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_comb begin
        o_ctl.load      = stage_ready & up_valid;
        o_ctl.in_ready  = stage_ready[0];
        o_ctl.out_valid = r_valid[NUM_STAGES-1];
    end

endmodule

@@ design/hsv_to_rgb_convert_core.sv @@
// hsv to rgb conversion core: four register stages, one transfer per clock unless stalled
// an input is registered in stages 1 to 4 in turn; output valid is stage 4's valid bit
// throughput: one item per cycle unless stalled; each stage loads on its own enable
// a stall holds full stages back to the first empty one; nothing is lost or repeated
// reset (synchronous, active low) clears the stage valid bits only
// depends on h2rgb_pkg, h2rgb_ifs and h2rgb_pipe_ctl

module hsv_to_rgb_convert_core
    import h2rgb_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    h2rgb_hsv_if.sink   i_hsv,
    h2rgb_rgb_if.source o_rgb
);

    t_pipe_ctl ctl;

    h2rgb_pipe_ctl u_ctl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_hsv.valid),
        .i_out_ready (o_rgb.ready),
        .o_ctl       (ctl)
    );

    assign i_hsv.ready = ctl.in_ready;
    assign o_rgb.valid = ctl.out_valid;

    // ---------------- stage 1: clamp, hue times six, sector and fraction
    t_level                 h_c;
    t_level                 s_c;
    t_level                 v_c;
    logic [H6_W-1:0]        h6;
    logic [SEC_W-1:0]       sec_raw;
    t_sector                n_sec1;
    logic [FRAC_BITS-1:0]   n_frac1;

    always_comb begin
        h_c     = clamp_one(i_hsv.hue);
        s_c     = clamp_one(i_hsv.saturation);
        v_c     = clamp_one(i_hsv.brightness);
        // times six as times four plus times two
        h6      = {h_c, 2'b00} + {1'b0, h_c, 1'b0};
        sec_raw = h6[H6_W-1:FRAC_BITS];
        n_sec1  = t_sector'(sec_raw);
        n_frac1 = h6[FRAC_BITS-1:0];
        // a full turn wraps to the first sector with no fraction
        if (n_sec1 == SEC_WRAP) begin
            n_sec1  = SEC_RED_YEL;
            n_frac1 = '0;
        end
    end

    t_sector              r_sec1;
    logic [FRAC_BITS-1:0] r_frac1;
    t_level               r_s1;
    t_level               r_v1;

    always_ff @(posedge i_clk) begin
        if (ctl.load[0]) begin
            r_sec1  <= n_sec1;
            r_frac1 <= n_frac1;
            r_s1    <= s_c;
            r_v1    <= v_c;
        end
    end

    // ---------------- stage 2: saturation scaled by fraction and its complement
    logic [FIELD_W+FRAC_BITS-1:0] sf_prod;
    logic [2*FIELD_W-1:0]         sfc_prod;
    t_level                       frac_c;
    t_level                       n_kp2;
    t_level                       n_kq2;
    t_level                       n_kt2;

    always_comb begin
        frac_c   = ONE_VAL - {1'b0, r_frac1};
        sf_prod  = r_s1 * r_frac1;
        sfc_prod = r_s1 * frac_c;
        n_kp2    = ONE_VAL - r_s1;
        n_kq2    = ONE_VAL - sf_prod[FRAC_BITS+FIELD_W-1:FRAC_BITS];
        n_kt2    = ONE_VAL - sfc_prod[FRAC_BITS+FIELD_W-1:FRAC_BITS];
    end

    t_sector r_sec2;
    logic    r_grey2;
    t_level  r_v2;
    t_level  r_kp2;
    t_level  r_kq2;
    t_level  r_kt2;

    always_ff @(posedge i_clk) begin
        if (ctl.load[1]) begin
            r_sec2  <= r_sec1;
            r_grey2 <= (r_s1 == '0);
            r_v2    <= r_v1;
            r_kp2   <= n_kp2;
            r_kq2   <= n_kq2;
            r_kt2   <= n_kt2;
        end
    end

    // ---------------- stage 3: the three levels p, q, t scaled by value
    logic [2*FIELD_W-1:0] p_prod;
    logic [2*FIELD_W-1:0] q_prod;
    logic [2*FIELD_W-1:0] t_prod;

    always_comb begin
        p_prod = r_v2 * r_kp2;
        q_prod = r_v2 * r_kq2;
        t_prod = r_v2 * r_kt2;
    end

    t_sector r_sec3;
    logic    r_grey3;
    t_level  r_v3;
    t_level  r_p3;
    t_level  r_q3;
    t_level  r_t3;

    always_ff @(posedge i_clk) begin
        if (ctl.load[2]) begin
            r_sec3  <= r_sec2;
            r_grey3 <= r_grey2;
            r_v3    <= r_v2;
            r_p3    <= p_prod[FRAC_BITS+FIELD_W-1:FRAC_BITS];
            r_q3    <= q_prod[FRAC_BITS+FIELD_W-1:FRAC_BITS];
            r_t3    <= t_prod[FRAC_BITS+FIELD_W-1:FRAC_BITS];
        end
    end

    // ---------------- stage 4: route by sector, scale to bytes, output register
    t_level lvl_r;
    t_level lvl_g;
    t_level lvl_b;

    always_comb begin
        unique case (r_sec3)
            SEC_RED_YEL: begin lvl_r = r_v3; lvl_g = r_t3; lvl_b = r_p3; end
            SEC_YEL_GRN: begin lvl_r = r_q3; lvl_g = r_v3; lvl_b = r_p3; end
            SEC_GRN_CYN: begin lvl_r = r_p3; lvl_g = r_v3; lvl_b = r_t3; end
            SEC_CYN_BLU: begin lvl_r = r_p3; lvl_g = r_q3; lvl_b = r_v3; end
            SEC_BLU_MAG: begin lvl_r = r_t3; lvl_g = r_p3; lvl_b = r_v3; end
            default:     begin lvl_r = r_v3; lvl_g = r_p3; lvl_b = r_q3; end
        endcase
        // zero saturation gives grey
        if (r_grey3) begin
            lvl_r = r_v3;
            lvl_g = r_v3;
            lvl_b = r_v3;
        end
    end

    t_byte r_red;
    t_byte r_green;
    t_byte r_blue;

    always_ff @(posedge i_clk) begin
        if (ctl.load[3]) begin
            r_red   <= to_byte(lvl_r);
            r_green <= to_byte(lvl_g);
            r_blue  <= to_byte(lvl_b);
        end
    end

    assign o_rgb.red   = r_red;
    assign o_rgb.green = r_green;
    assign o_rgb.blue  = r_blue;

endmodule

@@ tb/hsv_to_rgb_checker.sv @@
// checker for the hsv to rgb conversion core: predicts each rgb triple and compares
// watches both handshake channels as plain signals; depends on h2rgb_pkg

module hsv_to_rgb_checker
    import h2rgb_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_hsv_valid,
    input  logic   i_hsv_ready,
    input  t_level i_hue,
    input  t_level i_saturation,
    input  t_level i_brightness,
    input  logic   i_rgb_valid,
    input  logic   i_rgb_ready,
    input  t_byte  i_red,
    input  t_byte  i_green,
    input  t_byte  i_blue,
    output int     o_err_cnt,
    output int     o_pending,
    output int     o_checked
);

    typedef struct packed {
        t_byte red;
        t_byte green;
        t_byte blue;
    } t_rgb_px;

    t_rgb_px rgb_due_q[$];
    t_rgb_px want_px;
    t_rgb_px got_px;
    int      err_total = 0;
    int      checked   = 0;

    initial begin
        o_err_cnt = 0;
        o_pending = 0;
        o_checked = 0;
    end

    function automatic t_level sat_to_one(input t_level x);
        return (x > ONE_VAL) ? ONE_VAL : x;
    endfunction

    function automatic t_byte level_to_byte(input logic [31:0] lvl);
        return t_byte'((lvl * 32'd255) >> FRAC_BITS);
    endfunction

    function automatic t_rgb_px predict_rgb(input t_level hue_in, input t_level sat_in,
                                            input t_level val_in);
        t_level               h;
        t_level               s;
        t_level               v;
        logic [H6_W-1:0]      h6;
        logic [FRAC_BITS-1:0] frac;
        t_sector              sec;
        logic [31:0]          lvl_p;
        logic [31:0]          lvl_q;
        logic [31:0]          lvl_t;
        logic [31:0]          lvl_v;
        logic [31:0]          r;
        logic [31:0]          g;
        logic [31:0]          b;
        t_rgb_px              px;
        h     = sat_to_one(hue_in);
        s     = sat_to_one(sat_in);
        v     = sat_to_one(val_in);
        lvl_v = 32'(v);
        if (s == '0) begin
            r = lvl_v;
            g = lvl_v;
            b = lvl_v;
        end else begin
            h6   = H6_W'(32'(h) * 32'd6);
            sec  = t_sector'(h6[H6_W-1:FRAC_BITS]);
            frac = h6[FRAC_BITS-1:0];
            // a full turn folds back onto the red end of the first sector
            if (sec == SEC_WRAP) begin
                sec  = SEC_RED_YEL;
                frac = '0;
            end
            lvl_p = (lvl_v * (32'(ONE_VAL) - 32'(s))) >> FRAC_BITS;
            lvl_q = (lvl_v * (32'(ONE_VAL) - ((32'(s) * 32'(frac)) >> FRAC_BITS)))
                    >> FRAC_BITS;
            lvl_t = (lvl_v * (32'(ONE_VAL)
                    - ((32'(s) * (32'(ONE_VAL) - 32'(frac))) >> FRAC_BITS))) >> FRAC_BITS;
            case (sec)
                SEC_RED_YEL: begin r = lvl_v; g = lvl_t; b = lvl_p; end
                SEC_YEL_GRN: begin r = lvl_q; g = lvl_v; b = lvl_p; end
                SEC_GRN_CYN: begin r = lvl_p; g = lvl_v; b = lvl_t; end
                SEC_CYN_BLU: begin r = lvl_p; g = lvl_q; b = lvl_v; end
                SEC_BLU_MAG: begin r = lvl_t; g = lvl_p; b = lvl_v; end
                default: begin r = lvl_v; g = lvl_p; b = lvl_q; end
            endcase
        end
        px.red   = level_to_byte(r);
        px.green = level_to_byte(g);
        px.blue  = level_to_byte(b);
        return px;
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_hsv_valid && i_hsv_ready) begin
                rgb_due_q.push_back(predict_rgb(i_hue, i_saturation, i_brightness));
            end
            if (i_rgb_valid && i_rgb_ready) begin
                got_px = '{red: i_red, green: i_green, blue: i_blue};
                checked++;
                if (rgb_due_q.size() == 0) begin
                    err_total++;
                    $display("%0t: unexpected rgb transfer, expected none, got %02h %02h %02h",
                             $time, i_red, i_green, i_blue);
                end else begin
                    want_px = rgb_due_q.pop_front();
                    if (got_px !== want_px) begin
                        err_total++;
                        $display("%0t: rgb mismatch, expected %02h %02h %02h, got %02h %02h %02h",
                                 $time, want_px.red, want_px.green, want_px.blue,
                                 i_red, i_green, i_blue);
                    end
                end
            end
        end
        o_err_cnt <= err_total;
        o_pending <= rgb_due_q.size();
        o_checked <= checked;
    end

endmodule

@@ tb/tb_hsv_to_rgb_convert_core.sv @@
// testbench top for hsv_to_rgb_convert_core: clock, reset, stimulus and verdict
// depends on h2rgb_pkg, h2rgb_ifs, the core and hsv_to_rgb_checker

module tb_hsv_to_rgb_convert_core;
    import h2rgb_pkg::*;

    localparam int NUM_RANDOM     = 2000;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 20;

    logic clk = 1'b0;
    logic rst_n;
    logic burst_mode;   // when set, neither side inserts gaps
    int   n_sent = 0;
    int   idle_cycles = 0;
    int   err_cnt;
    int   pending;
    int   checked;

    h2rgb_hsv_if hsv_ch();
    h2rgb_rgb_if rgb_ch();

    always #10 clk = ~clk;

    hsv_to_rgb_convert_core dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_hsv   (hsv_ch),
        .o_rgb   (rgb_ch)
    );

    hsv_to_rgb_checker rgb_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_hsv_valid  (hsv_ch.valid),
        .i_hsv_ready  (hsv_ch.ready),
        .i_hue        (hsv_ch.hue),
        .i_saturation (hsv_ch.saturation),
        .i_brightness (hsv_ch.brightness),
        .i_rgb_valid  (rgb_ch.valid),
        .i_rgb_ready  (rgb_ch.ready),
        .i_red        (rgb_ch.red),
        .i_green      (rgb_ch.green),
        .i_blue       (rgb_ch.blue),
        .o_err_cnt    (err_cnt),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    // idle length: mostly none or a few cycles, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (burst_mode || r < 55)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // field value: mostly inside 0..one, some corners, some above one
    function automatic t_level pick_field();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return t_level'($urandom_range(0, 4096));
        else if (r < 80)
            case ($urandom_range(0, 3))
                0: return '0;
                1: return ONE_VAL;
                2: return t_level'(1);
                default: return t_level'(ONE_VAL - 1);
            endcase
        else if (r < 88)
            return t_level'($urandom_range(4097, 8191));
        else
            return t_level'($urandom_range(0, 8191));
    endfunction

    // one hsv transfer; entered and left on a falling edge, valid kept high
    // across back-to-back transfers so it is never dropped and raised in one step
    task automatic send_hsv(input t_level h, input t_level s, input t_level v);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            hsv_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        hsv_ch.valid      <= 1'b1;
        hsv_ch.hue        <= h;
        hsv_ch.saturation <= s;
        hsv_ch.brightness <= v;
        do @(posedge clk); while (!hsv_ch.ready);
        n_sent++;
        @(negedge clk);
    endtask

    // hold the sender until every predicted triple has come out
    task automatic drain_pipe();
        hsv_ch.valid <= 1'b0;
        wait (pending == 0);
        @(negedge clk);
    endtask

    // receiver: runs of ready with stalls of random length in between
    initial begin
        int run;
        int stall;
        rgb_ch.ready = 1'b0;
        @(negedge clk);
        forever begin
            run = $urandom_range(1, 30);
            rgb_ch.ready <= 1'b1;
            repeat (run) @(negedge clk);
            stall = pick_gap();
            if (stall > 0) begin
                rgb_ch.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
        end
    end

    // watchdog: a run of cycles longer than the watchdog limit without a transfer on either side is a hang
    always @(posedge clk) begin
        if ((hsv_ch.valid && hsv_ch.ready) || (rgb_ch.valid && rgb_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("DONE: errors detected");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int     sec_lo;
        int     sec_hi;
        t_level h;
        t_level s;
        t_level v;
        rst_n             = 1'b0;
        burst_mode        = 1'b0;
        hsv_ch.valid      = 1'b0;
        hsv_ch.hue        = '0;
        hsv_ch.saturation = '0;
        hsv_ch.brightness = '0;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: black, white and the corners of the fields
        send_hsv('0, '0, '0);
        send_hsv(ONE_VAL, ONE_VAL, ONE_VAL);
        send_hsv(t_level'(ONE_VAL - 1), ONE_VAL, ONE_VAL);
        // zero saturation gives grey whatever the hue
        send_hsv(13'd1000, '0, ONE_VAL);
        send_hsv(13'd3000, '0, 13'd2048);
        send_hsv('0, '0, 13'd1);
        // full hue wraps to the start of the red sector
        send_hsv(ONE_VAL, 13'd2048, 13'd3000);
        // inputs above one saturate to one
        send_hsv(13'h1FFF, ONE_VAL, ONE_VAL);
        send_hsv(13'd2000, 13'h1FFF, ONE_VAL);
        send_hsv(13'd2000, ONE_VAL, 13'h1FFF);
        send_hsv(13'h1FFF, 13'h1FFF, 13'h1FFF);
        send_hsv(t_level'(ONE_VAL + 1), 13'd1, t_level'(ONE_VAL + 1));
        // first and last hue of each sector
        for (int k = 0; k < 6; k++) begin
            sec_lo = (k * 4096 + 5) / 6;
            sec_hi = ((k + 1) * 4096 + 5) / 6 - 1;
            send_hsv(t_level'(sec_lo), ONE_VAL, ONE_VAL);
            send_hsv(t_level'(sec_hi), 13'd2048, 13'd3000);
        end

        // random part, with two pauses for a full drain and a gap-free stretch
        for (int i = 0; i < NUM_RANDOM; i++) begin
            if (i == 600 || i == 1500)
                drain_pipe();
            burst_mode = (i >= 900 && i < 1200);
            h = pick_field();
            s = ($urandom_range(0, 19) == 0) ? t_level'(0) : pick_field();
            v = pick_field();
            send_hsv(h, s, v);
        end
        burst_mode   = 1'b0;
        hsv_ch.valid <= 1'b0;

        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);

        $display("sent %0d hsv triples (corners, sector edges, full hue, grey, over-range)",
                 n_sent);
        $display("checked %0d rgb triples under random gaps and output stalls", checked);
        if (err_cnt == 0 && pending == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

@@ files.f @@
design/h2rgb_pkg.sv
design/h2rgb_ifs.sv
design/h2rgb_pipe_ctl.sv
design/hsv_to_rgb_convert_core.sv
tb/hsv_to_rgb_checker.sv
tb/tb_hsv_to_rgb_convert_core.sv
